FILE: rtl/psu_pkg.sv
// Shared types, register indexes and filter arithmetic for the PNG scanline unfilter.
`default_nettype none

package psu_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // highest legal filter type code
  localparam logic [7:0] FILT_LAST = 8'd4;

  typedef enum logic [1:0] {
    REG_ROW_BYTES   = 2'd0,
    REG_PIXEL_BYTES = 2'd1,
    REG_IMAGE_ROWS  = 2'd2
  } reg_idx_t;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [8:0] pa;
    logic [8:0] pb;
    logic [8:0] pc;
    logic [8:0] sum;
    logic [8:0] c2;
    pa  = (b > c) ? {1'b0, b - c} : {1'b0, c - b};
    pb  = (a > c) ? {1'b0, a - c} : {1'b0, c - a};
    sum = {1'b0, a} + {1'b0, b};
    c2  = {c, 1'b0};
    pc  = (sum > c2) ? sum - c2 : c2 - sum;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  function automatic logic [7:0] recon(input filter_t filt, input logic [7:0] x,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [8:0] avg;
    logic [7:0] pred;
    avg = {1'b0, a} + {1'b0, b};
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'd0;
    endcase
    return x + pred;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter: filter-byte parsing, row store and byte reconstruction.
// Throughput: one stream word per cycle, filter bytes included, while out_ready does not stall the output.
// Each accepted data word is registered in the reconstruct stage and then in the output register.
// Rate is set by the row store read, issued on the accept edge, and the reconstruct stage
// that uses its registered data together with the left and above-left history.
// Reset clears control state and the left/above-left history; the row store is not
// cleared (the first row of every image reads the row above as zero).
`default_nettype none

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // stream in
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] stream_byte,
  input  wire logic       start_of_image,
  // result out
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      pixel_byte,
  output logic            status,
  output logic            row_end,
  output logic            image_end,
  // config
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int CW  = $clog2(MAX_ROW_BYTES);
  localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
  localparam int REW = (RBW > 15) ? RBW : 15;
  localparam int PBW = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int PEW = (PBW > 3) ? PBW : 3;
  localparam int HW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  typedef struct packed {
    logic          err;
    logic [7:0]    data;
    filter_t       filt;
    logic          first_row;
    logic          has_left;
    logic [HW-1:0] hsel;
    logic [CW-1:0] col;
    logic          row_end;
    logic          image_end;
  } stage_t;

  // config registers
  logic [14:0] row_len;
  logic [2:0]  bytes_per_pixel;
  logic [12:0] image_rows;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len         <= 15'd3;
      bytes_per_pixel <= 3'd3;
      image_rows      <= 13'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_BYTES:   row_len         <= pwdata[14:0];
        REG_PIXEL_BYTES: bytes_per_pixel <= pwdata[2:0];
        REG_IMAGE_ROWS:  image_rows      <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_BYTES:   prdata = {17'd0, row_len};
      REG_PIXEL_BYTES: prdata = {29'd0, bytes_per_pixel};
      REG_IMAGE_ROWS:  prdata = {19'd0, image_rows};
      default:         prdata = 32'd0;
    endcase
  end

  // clamped config
  logic [REW-1:0] rb_ext;
  logic [RBW-1:0] rb_eff;
  logic [PEW-1:0] bpp_ext;
  logic [PBW-1:0] bpp_eff;
  logic [12:0]    rows_eff;

  always_comb begin
    rb_ext = REW'(row_len);
    if (rb_ext == '0) begin
      rb_eff = RBW'(1);
    end else if (rb_ext > REW'(MAX_ROW_BYTES)) begin
      rb_eff = RBW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = RBW'(rb_ext);
    end
    bpp_ext = PEW'(bytes_per_pixel);
    if (bpp_ext == '0) begin
      bpp_eff = PBW'(1);
    end else if (bpp_ext > PEW'(MAX_PIXEL_BYTES)) begin
      bpp_eff = PBW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = PBW'(bpp_ext);
    end
    rows_eff = (image_rows == 13'd0) ? 13'd1 : image_rows;
  end

  // parse state
  filter_t       filt, filt_next;
  logic          awaiting, awaiting_next;
  logic          first_row, first_row_next;
  logic          halted, halted_next;
  logic [CW-1:0] col, col_next;
  logic [12:0]   row, row_next;

  stage_t s, s_new;
  logic   s_valid;
  logic   s_load;
  logic   s_go;
  logic   in_acc;

  logic          e_awaiting;
  logic          e_first;
  logic [CW-1:0] e_col;
  logic [12:0]   e_row;
  logic          d_row_end;
  logic          d_image_end;

  assign s_go     = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || s_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    e_awaiting  = start_of_image ? 1'b1 : awaiting;
    e_first     = start_of_image ? 1'b1 : first_row;
    e_col       = start_of_image ? '0 : col;
    e_row       = start_of_image ? 13'd0 : row;
    d_row_end   = (RBW'(e_col) + RBW'(1)) >= rb_eff;
    d_image_end = d_row_end && (({1'b0, e_row} + 14'd1) >= {1'b0, rows_eff});

    filt_next      = filt;
    awaiting_next  = e_awaiting;
    first_row_next = e_first;
    halted_next    = start_of_image ? 1'b0 : halted;
    col_next       = e_col;
    row_next       = e_row;
    s_load         = 1'b0;

    s_new           = '0;
    s_new.data      = stream_byte;
    s_new.filt      = filt;
    s_new.first_row = e_first;
    s_new.has_left  = 32'(e_col) >= 32'(bpp_eff);
    s_new.hsel      = HW'(bpp_eff - PBW'(1));
    s_new.col       = e_col;
    s_new.row_end   = d_row_end;
    s_new.image_end = d_image_end;

    if (halted_next) begin
      // dropped until the next start of image
    end else if (e_awaiting) begin
      if (stream_byte > FILT_LAST) begin
        halted_next = 1'b1;
        s_load      = 1'b1;
        s_new.err   = 1'b1;
      end else begin
        filt_next     = filter_t'(stream_byte[2:0]);
        awaiting_next = 1'b0;
        col_next      = '0;
      end
    end else begin
      s_load = 1'b1;
      if (d_image_end) begin
        col_next       = '0;
        row_next       = 13'd0;
        awaiting_next  = 1'b1;
        first_row_next = 1'b1;
      end else if (d_row_end) begin
        col_next       = '0;
        row_next       = e_row + 13'd1;
        awaiting_next  = 1'b1;
        first_row_next = 1'b0;
      end else begin
        col_next = e_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt      <= FILT_NONE;
      awaiting  <= 1'b1;
      first_row <= 1'b1;
      halted    <= 1'b0;
      col       <= '0;
      row       <= 13'd0;
    end else if (in_acc) begin
      filt      <= filt_next;
      awaiting  <= awaiting_next;
      first_row <= first_row_next;
      halted    <= halted_next;
      col       <= col_next;
      row       <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_acc) begin
      s_valid <= s_load;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s <= s_new;
    end
  end

  // row store: read on accept, written back from the reconstruct stage
  logic [7:0] above_row_store [MAX_ROW_BYTES];
  logic [7:0] above_rd;
  logic       st_wr;
  logic [7:0] recon_v;

  assign st_wr = s_go && !s.err;

  always_ff @(posedge clk) begin
    if (st_wr) begin
      above_row_store[s.col] <= recon_v;
    end
    if (in_acc) begin
      above_rd <= above_row_store[e_col];
    end
  end

  // reconstruct
  logic [7:0] left_hist  [MAX_PIXEL_BYTES];
  logic [7:0] aleft_hist [MAX_PIXEL_BYTES];
  logic [7:0] va, vb, vc;

  always_comb begin
    va      = s.has_left ? left_hist[s.hsel] : 8'd0;
    vc      = s.has_left ? aleft_hist[s.hsel] : 8'd0;
    vb      = s.first_row ? 8'd0 : above_rd;
    recon_v = recon(s.filt, s.data, va, vb, vc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= 8'd0;
        aleft_hist[i] <= 8'd0;
      end
    end else if (st_wr) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i]  <= left_hist[i-1];
        aleft_hist[i] <= aleft_hist[i-1];
      end
      left_hist[0]  <= recon_v;
      aleft_hist[0] <= vb;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      pixel_byte <= s.err ? 8'd0 : recon_v;
      status     <= s.err;
      row_end    <= s.err ? 1'b0 : s.row_end;
      image_end  <= s.err ? 1'b0 : s.image_end;
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> pixel_byte == 8'd0 && !row_end && !image_end)
    else $error("error word carries data or end marks");

  a_img_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> row_end)
    else $error("image end without row end");

  a_halt_drop: assert property (@(posedge clk) disable iff (rst)
    in_acc && halted && !start_of_image |=> !s_valid)
    else $error("word taken into stage while halted");

  a_filter_take: assert property (@(posedge clk) disable iff (rst)
    in_acc && !halted && awaiting && !start_of_image && stream_byte <= FILT_LAST
    |=> !awaiting && col == '0)
    else $error("filter byte not taken");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_go |=> s_valid && $stable(s))
    else $error("stalled stage lost its word");

endmodule

`default_nettype wire
